>>> src/pdep_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pdep_pkg
// Shared constants and types for the directory entry parser.
// ============================================================================
package pdep_pkg;

    // Largest block, in bytes, and the widths that follow from it
    localparam int BLOCK_BYTES    = 256;
    localparam int RC_W           = 9;
    localparam int POS_W          = $clog2(BLOCK_BYTES + 1);
    localparam int LEN_W          = 16;

    // Entry layout
    localparam int HEAD_BYTES     = 12;
    localparam int SENTINEL_BYTES = 8;
    localparam int OFS_W          = 7;
    localparam int DRAIN_W        = $clog2(HEAD_BYTES);
    localparam logic [4:0] SIZE_MASK     = 5'h1F;
    localparam logic [7:0] SENTINEL_BYTE = 8'hFF;
    localparam int START_RESET    = 2;

    // One result of the parser
    typedef struct packed {
        logic [7:0] entry_byte;
        logic       first_of_entry;
        logic       last_of_entry;
        logic       directory_end;
        logic       run_last;
    } t_result;

endpackage

>>> src/pds_directory_entry_parser_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// pds_directory_entry_parser_unit
// Parses raw directory blocks into entry bytes with first and last marks.
// ============================================================================
// Each accepted byte is parsed against the block state in a single pass,
// and a byte that yields a result lands in the output register, so bytes
// stream at one per cycle while the receiver is ready. When the twelfth head
// byte of an accepted entry arrives, the first head byte goes to the output
// register and the rest follow one per cycle from a drain register while
// the receiver is ready; input is held off until the drain is empty. After
// the directory ends (sentinel entry or short read) input is taken but ignored.
module pds_directory_entry_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input requests
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic [8:0] i_read_count,
    // results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_entry_byte,
    output logic       o_first_of_entry,
    output logic       o_last_of_entry,
    output logic       o_directory_end,
    output logic       o_run_last
);

    localparam int POS_W = pdep_pkg::POS_W;
    localparam int LEN_W = pdep_pkg::LEN_W;
    localparam int OFS_W = pdep_pkg::OFS_W;
    localparam int HB    = pdep_pkg::HEAD_BYTES;
    localparam int DW    = pdep_pkg::DRAIN_W;

    // Block state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [OFS_W-1:0] r_ofs,   n_ofs;
    logic [OFS_W-1:0] r_size,  n_size;
    logic [POS_W-1:0] r_start, n_start;
    logic             r_skip,  n_skip;
    logic             r_done,  n_done;

    // Head bytes 0..10, oldest at index 0
    logic [7:0] r_head [HB-1];
    logic [7:0] n_head [HB-1];
    logic       head_shift;

    // Drain of head bytes 1..11
    logic [7:0]   r_drain [HB-1];
    logic [7:0]   n_drain [HB-1];
    logic [DW-1:0] r_drain_cnt, n_drain_cnt;
    logic         r_drain_last, n_drain_last;

    // Output register
    logic               r_out_valid, n_out_valid;
    pdep_pkg::t_result  r_out, n_out;

    logic in_fire;
    logic out_fire;
    logic out_free;

    // Parse results for the current request
    logic [POS_W-1:0] rc_cap;
    logic [POS_W-1:0] cur_len;
    logic [OFS_W-1:0] size_calc;
    logic [OFS_W-1:0] ofs_inc;
    logic             sentinel;
    logic             emit;
    logic             emit_head;
    pdep_pkg::t_result res;

    assign out_fire   = r_out_valid && i_out_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_drain_cnt == '0) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Cap the read count and the block length
    always_comb begin
        if (i_read_count > pdep_pkg::RC_W'(pdep_pkg::BLOCK_BYTES)) begin
            rc_cap = POS_W'(pdep_pkg::BLOCK_BYTES);
        end else begin
            rc_cap = POS_W'(i_read_count);
        end
        if (r_len < LEN_W'(rc_cap)) begin
            cur_len = r_len[POS_W-1:0];
        end else begin
            cur_len = rc_cap;
        end
    end

    // Sentinel check on buffered head and entry size from head byte 11
    always_comb begin
        sentinel = 1'b1;
        for (int k = 0; k < pdep_pkg::SENTINEL_BYTES; k++) begin
            if (r_head[k] != pdep_pkg::SENTINEL_BYTE) begin
                sentinel = 1'b0;
            end
        end
        size_calc = OFS_W'(HB) + {1'b0, i_data_byte[4:0] & pdep_pkg::SIZE_MASK, 1'b0};
        ofs_inc   = r_ofs + OFS_W'(1);
    end

    // Parse one request against the block state
    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_ofs      = r_ofs;
        n_size     = r_size;
        n_start    = r_start;
        n_skip     = r_skip;
        n_done     = r_done;
        head_shift = 1'b0;
        emit       = 1'b0;
        emit_head  = 1'b0;
        res        = '0;

        if (in_fire && !r_done) begin
            if (rc_cap < POS_W'(2)) begin
                // short read ends the directory
                n_done            = 1'b1;
                emit              = 1'b1;
                res.directory_end = 1'b1;
                res.run_last      = 1'b1;
            end else begin
                if (r_pos == '0) begin
                    n_len = {i_data_byte, 8'h00};
                end else if (r_pos == POS_W'(1)) begin
                    n_len = {r_len[LEN_W-1:8], i_data_byte};
                end else if (!r_skip) begin
                    if (r_ofs == '0) begin
                        if (r_pos == r_start) begin
                            if (({1'b0, r_pos} + (POS_W+1)'(HB)) > {1'b0, cur_len}) begin
                                n_skip = 1'b1;
                            end else begin
                                head_shift = 1'b1;
                                n_ofs      = OFS_W'(1);
                            end
                        end
                    end else if (r_ofs < OFS_W'(HB)) begin
                        n_ofs = ofs_inc;
                        if (r_ofs != OFS_W'(HB - 1)) begin
                            head_shift = 1'b1;
                        end else if (sentinel) begin
                            // end-of-directory entry
                            n_done            = 1'b1;
                            emit              = 1'b1;
                            res.directory_end = 1'b1;
                            res.run_last      = 1'b1;
                        end else begin
                            n_size = size_calc;
                            if (({1'b0, r_start} + (POS_W+1)'(size_calc))
                                    > {1'b0, cur_len}) begin
                                // entry overruns the block: drop the rest
                                n_skip = 1'b1;
                                n_ofs  = '0;
                            end else begin
                                emit               = 1'b1;
                                emit_head          = 1'b1;
                                res.entry_byte     = r_head[0];
                                res.first_of_entry = 1'b1;
                                if (size_calc == OFS_W'(HB)) begin
                                    n_ofs   = '0;
                                    n_start = r_start + POS_W'(HB);
                                end
                            end
                        end
                    end else begin
                        // user data bytes
                        n_ofs          = ofs_inc;
                        emit           = 1'b1;
                        res.entry_byte = i_data_byte;
                        res.run_last   = 1'b1;
                        if (ofs_inc >= r_size) begin
                            res.last_of_entry = 1'b1;
                            n_ofs             = '0;
                            n_start           = r_start + POS_W'(r_size);
                        end
                    end
                end

                // advance or close the block
                if (!n_done) begin
                    if (({1'b0, r_pos} + (POS_W+1)'(1)) >= {1'b0, rc_cap}) begin
                        n_pos   = '0;
                        n_len   = '0;
                        n_ofs   = '0;
                        n_size  = '0;
                        n_start = POS_W'(pdep_pkg::START_RESET);
                        n_skip  = 1'b0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

    // Head shift line and drain register
    always_comb begin
        for (int k = 0; k < HB - 1; k++) begin
            n_head[k]  = r_head[k];
            n_drain[k] = r_drain[k];
        end
        n_drain_cnt  = r_drain_cnt;
        n_drain_last = r_drain_last;

        if (head_shift) begin
            for (int k = 0; k < HB - 2; k++) begin
                n_head[k] = r_head[k + 1];
            end
            n_head[HB-2] = i_data_byte;
        end

        if (emit_head) begin
            for (int k = 0; k < HB - 2; k++) begin
                n_drain[k] = r_head[k + 1];
            end
            n_drain[HB-2] = i_data_byte;
            n_drain_cnt   = DW'(HB - 1);
            n_drain_last  = (size_calc == OFS_W'(HB));
        end else if (r_drain_cnt != '0 && out_free) begin
            for (int k = 0; k < HB - 2; k++) begin
                n_drain[k] = r_drain[k + 1];
            end
            n_drain_cnt = r_drain_cnt - DW'(1);
        end
    end

    // Output register: drain first, then new results
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_drain_cnt != '0 && out_free) begin
            n_out_valid              = 1'b1;
            n_out.entry_byte         = r_drain[0];
            n_out.first_of_entry     = 1'b0;
            n_out.last_of_entry      = (r_drain_cnt == DW'(1)) && r_drain_last;
            n_out.directory_end      = 1'b0;
            n_out.run_last           = (r_drain_cnt == DW'(1));
        end else if (in_fire && emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_ofs       <= '0;
            r_size      <= '0;
            r_start     <= POS_W'(pdep_pkg::START_RESET);
            r_skip      <= 1'b0;
            r_done      <= 1'b0;
            r_drain_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_ofs       <= n_ofs;
            r_size      <= n_size;
            r_start     <= n_start;
            r_skip      <= n_skip;
            r_done      <= n_done;
            r_drain_cnt <= n_drain_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HB - 1; k++) begin
            r_head[k]  <= n_head[k];
            r_drain[k] <= n_drain[k];
        end
        r_drain_last <= n_drain_last;
        r_out        <= n_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_entry_byte     = r_out.entry_byte;
    assign o_first_of_entry = r_out.first_of_entry;
    assign o_last_of_entry  = r_out.last_of_entry;
    assign o_directory_end  = r_out.directory_end;
    assign o_run_last       = r_out.run_last;

endmodule

>>> src/pdep_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pdep_checker
// Port-level checks of the directory entry parser.
// ============================================================================
module pdep_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_entry_byte,
    input logic       o_first_of_entry,
    input logic       o_last_of_entry,
    input logic       o_directory_end,
    input logic       o_run_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entry_byte)
            && $stable(o_run_last) && $stable(o_directory_end))
        else $error("stalled result changed");

    // End result is bare and closes its run
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_directory_end |-> o_run_last && (o_entry_byte == 8'h00)
            && !o_first_of_entry && !o_last_of_entry)
        else $error("malformed end result");

    // Nothing follows the end result
    a_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_directory_end |=> !o_out_valid)
        else $error("result after end of directory");

    // First byte of an entry opens a twelve-byte head run
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_first_of_entry |-> !o_run_last && !o_last_of_entry)
        else $error("first head byte closes its run");

    // A run continues in the next cycle
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_last |=> o_out_valid && !o_first_of_entry)
        else $error("head run broken");

endmodule

bind pds_directory_entry_parser_unit pdep_checker u_pdep_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_entry_byte     (o_entry_byte),
    .o_first_of_entry (o_first_of_entry),
    .o_last_of_entry  (o_last_of_entry),
    .o_directory_end  (o_directory_end),
    .o_run_last       (o_run_last)
);

>>> tb/tb_pds_directory_entry_parser_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_pds_directory_entry_parser_unit
// Self-checking bench for the directory entry parser.
// ============================================================================
// Feeds directory blocks one byte per request. A short hand-built part comes
// first, then random blocks. Most random blocks are well formed: a length,
// then packed entries with random content. The rest carry short lengths,
// raw noise or a read count that shrinks partway through. A scoreboard class
// tracks the block state, predicts every entry byte and checks the results
// in order. The run closes with the end of the directory, caused either by
// a sentinel entry or by a short read, followed by a few ignored requests.
// Both sides idle at random. Once the receiver stalls long enough to back up
// the input, and once the sender waits for the output to drain.
// ============================================================================
module tb_pds_directory_entry_parser_unit;

    localparam int LONG_STALL_CYCLES = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic [8:0] i_read_count;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_entry_byte;
    logic       o_first_of_entry;
    logic       o_last_of_entry;
    logic       o_directory_end;
    logic       o_run_last;

    bit         gaps_enabled   = 1'b1;
    bit         long_stall_req = 1'b0;

    // Requests waiting to be sent
    logic [7:0] stim_bytes  [$];
    logic [8:0] stim_counts [$];

    // ------------------------------------------------------------------------
    // Parser state tracking and in-order result checking
    // ------------------------------------------------------------------------
    class dir_entry_scoreboard;
        logic [8:0]         blk_pos;
        logic [15:0]        blk_len;
        logic [6:0]         ent_ofs;
        logic [6:0]         ent_size;
        logic [8:0]         ent_start;
        logic [7:0]         head_buf [pdep_pkg::HEAD_BYTES];
        bit                 skip_block;
        bit                 dir_done;
        pdep_pkg::t_result  expected_bytes [$];
        int                 errors;

        function new();
            clear_block();
            dir_done = 1'b0;
            errors   = 0;
        endfunction

        function void clear_block();
            blk_pos    = '0;
            blk_len    = '0;
            ent_ofs    = '0;
            ent_size   = '0;
            ent_start  = 9'(pdep_pkg::START_RESET);
            skip_block = 1'b0;
        endfunction

        function pdep_pkg::t_result make_result(logic [7:0] b, logic first, logic last,
                                                logic fin);
            pdep_pkg::t_result r;
            r.entry_byte     = b;
            r.first_of_entry = first;
            r.last_of_entry  = last;
            r.directory_end  = fin;
            r.run_last       = 1'b0;
            return r;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Advance the block state by one accepted request
        function void note_request(logic [7:0] b, logic [8:0] rc_in);
            int                rc;
            int                pos;
            int                len;
            bit                sentinel;
            pdep_pkg::t_result batch [$];
            if (dir_done) return;
            rc = (int'(rc_in) > pdep_pkg::BLOCK_BYTES) ? pdep_pkg::BLOCK_BYTES
                                                       : int'(rc_in);
            if (rc < 2) begin
                // short read ends the directory
                dir_done = 1'b1;
                batch.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
            end else begin
                pos = int'(blk_pos);
                if (pos == 0) begin
                    blk_len = {b, 8'h00};
                end else if (pos == 1) begin
                    blk_len[7:0] = b;
                end else if (!skip_block) begin
                    len = (int'(blk_len) < rc) ? int'(blk_len) : rc;
                    if (ent_ofs == 0) begin
                        // entry start: drop the rest if the head cannot fit
                        if (pos == int'(ent_start)) begin
                            if (pos + pdep_pkg::HEAD_BYTES > len) begin
                                skip_block = 1'b1;
                            end else begin
                                head_buf[0] = b;
                                ent_ofs     = 7'd1;
                            end
                        end
                    end else if (ent_ofs < pdep_pkg::HEAD_BYTES) begin
                        head_buf[ent_ofs] = b;
                        ent_ofs++;
                        if (ent_ofs == pdep_pkg::HEAD_BYTES) begin
                            sentinel = 1'b1;
                            for (int i = 0; i < pdep_pkg::SENTINEL_BYTES; i++) begin
                                if (head_buf[i] != pdep_pkg::SENTINEL_BYTE) sentinel = 1'b0;
                            end
                            ent_size = 7'(pdep_pkg::HEAD_BYTES
                                + 2 * int'(head_buf[11][4:0] & pdep_pkg::SIZE_MASK));
                            if (sentinel) begin
                                dir_done = 1'b1;
                                batch.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
                            end else if (int'(ent_start) + int'(ent_size) > len) begin
                                // entry overruns the length: drop it and the block
                                skip_block = 1'b1;
                                ent_ofs    = '0;
                            end else begin
                                for (int i = 0; i < pdep_pkg::HEAD_BYTES; i++) begin
                                    batch.push_back(make_result(head_buf[i], i == 0,
                                        (i == pdep_pkg::HEAD_BYTES - 1)
                                            && (ent_size == pdep_pkg::HEAD_BYTES),
                                        1'b0));
                                end
                                if (ent_size == pdep_pkg::HEAD_BYTES) begin
                                    ent_ofs   = '0;
                                    ent_start = ent_start + 9'(pdep_pkg::HEAD_BYTES);
                                end
                            end
                        end
                    end else begin
                        // user data byte
                        ent_ofs++;
                        if (ent_ofs >= ent_size) begin
                            batch.push_back(make_result(b, 1'b0, 1'b1, 1'b0));
                            ent_ofs   = '0;
                            ent_start = ent_start + 9'(ent_size);
                        end else begin
                            batch.push_back(make_result(b, 1'b0, 1'b0, 1'b0));
                        end
                    end
                end
                if (pos + 1 >= rc) clear_block();
                else blk_pos = 9'(pos + 1);
            end
            if (batch.size() != 0) batch[batch.size() - 1].run_last = 1'b1;
            foreach (batch[i]) expected_bytes.push_back(batch[i]);
        endfunction

        function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
            if (got !== exp) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
            end
        endfunction

        // Match one result against the oldest prediction
        function void check_result(pdep_pkg::t_result got);
            pdep_pkg::t_result exp;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            exp = expected_bytes.pop_front();
            compare_field("entry_byte", exp.entry_byte, got.entry_byte);
            compare_field("first_of_entry", 8'(exp.first_of_entry), 8'(got.first_of_entry));
            compare_field("last_of_entry", 8'(exp.last_of_entry), 8'(got.last_of_entry));
            compare_field("directory_end", 8'(exp.directory_end), 8'(got.directory_end));
            compare_field("run_last", 8'(exp.run_last), 8'(got.run_last));
        endfunction
    endclass

    dir_entry_scoreboard sb = new();

    pds_directory_entry_parser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_read_count     (i_read_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_entry_byte     (o_entry_byte),
        .o_first_of_entry (o_first_of_entry),
        .o_last_of_entry  (o_last_of_entry),
        .o_directory_end  (o_directory_end),
        .o_run_last       (o_run_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_data_byte, i_read_count);
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_entry_byte, o_first_of_entry, o_last_of_entry,
                                 o_directory_end, o_run_last});
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
                long_stall_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (gaps_enabled && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until taken
    task automatic send_request(input logic [7:0] b, input logic [8:0] rc);
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_read_count <= rc;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_queued();
        while (stim_bytes.size() != 0) begin
            send_request(stim_bytes.pop_front(), stim_counts.pop_front());
        end
    endtask

    function automatic void queue_block(input logic [7:0] blk [$], input logic [8:0] rc);
        foreach (blk[i]) begin
            stim_bytes.push_back(blk[i]);
            stim_counts.push_back(rc);
        end
    endfunction

    // Build one random block; clean forces a full-length, well-formed block
    function automatic void build_block(input bit clean);
        int         kind;
        int         n;
        int         len;
        int         low5;
        int         cut;
        int         m;
        logic [7:0] blk [$];
        kind = clean ? 0 : $urandom_range(0, 9);
        if (clean) n = $urandom_range(40, 56);
        else if ($urandom_range(0, 7) == 0) n = $urandom_range(2, 13);
        else n = $urandom_range(14, 56);
        // length field: exact, oversized (capped), or short
        if (kind < 6) len = ($urandom_range(0, 3) == 0) ? $urandom_range(n, 65535) : n;
        else len = $urandom_range(0, n);
        blk.push_back(8'(len >> 8));
        blk.push_back(8'(len));
        while (blk.size() < n) begin
            if (kind == 9) begin
                blk.push_back(8'($urandom));
            end else begin
                low5 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
                for (int i = 0; i < pdep_pkg::HEAD_BYTES - 1; i++) blk.push_back(8'($urandom));
                blk.push_back({3'($urandom), 5'(low5)});
                for (int i = 0; i < 2 * low5; i++) blk.push_back(8'($urandom));
            end
        end
        while (blk.size() > n) void'(blk.pop_back());
        // occasionally shrink the read count partway through the block
        cut = n;
        m   = n;
        if (!clean && n > 4 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(2, n - 2);
            m   = $urandom_range(cut + 1, n - 1);
        end
        for (int i = 0; i < m; i++) begin
            stim_bytes.push_back(blk[i]);
            if (i == 0 && $urandom_range(0, 3) == 0)
                stim_counts.push_back(9'($urandom_range(128, pdep_pkg::BLOCK_BYTES)));
            else
                stim_counts.push_back(9'((i < cut) ? n : m));
        end
    endfunction

    task automatic run_blocks(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            build_block(1'b0);
            sent += stim_bytes.size();
            send_queued();
        end
    endtask

    // End the directory by sentinel or short read, then a few ignored requests
    function automatic void queue_directory_end();
        int         n;
        logic [7:0] blk [$];
        if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(14, 40);
            blk.push_back(8'h00);
            blk.push_back(8'(n));
            repeat (pdep_pkg::SENTINEL_BYTES) blk.push_back(pdep_pkg::SENTINEL_BYTE);
            while (blk.size() < n) blk.push_back(8'($urandom));
            queue_block(blk, 9'(n));
        end else begin
            stim_bytes.push_back(8'($urandom));
            stim_counts.push_back(9'($urandom_range(0, 1)));
        end
        repeat (4) begin
            stim_bytes.push_back(8'($urandom));
            stim_counts.push_back(9'($urandom_range(0, pdep_pkg::BLOCK_BYTES)));
        end
    endfunction

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Main sequence
    initial begin
        logic [7:0] blk [$];
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= '0;
        i_read_count <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 14-byte block, one head-only entry that opens with seven 0xFF bytes, one short of a sentinel
        blk = '{8'h00, 8'h0E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                8'h80, 8'h7F, 8'h01, 8'hE0};
        queue_block(blk, 9'd14);
        stim_counts[0] = 9'd256;
        // oversized length capped to 17: one entry with user data, then no room
        blk = '{8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h3C, 8'hC3, 8'hFF, 8'h00,
                8'h12, 8'h34, 8'h56, 8'h21, 8'h00, 8'hFF, 8'h77};
        queue_block(blk, 9'd17);
        stim_counts[14] = 9'd255;
        send_queued();

        run_blocks(50);

        // long receiver hold-off while a dense block keeps coming
        long_stall_req = 1'b1;
        build_block(1'b1);
        send_queued();
        run_blocks(35);

        // let the output catch up completely before going on
        drain_results();
        run_blocks(35);

        gaps_enabled = 1'b0;
        run_blocks(25);
        queue_directory_end();
        send_queued();

        drain_results();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
src/pdep_pkg.sv
src/pds_directory_entry_parser_unit.sv
src/pdep_checker.sv
tb/tb_pds_directory_entry_parser_unit.sv
